// File: rtl/core/dns_pkg.sv
// Shared constants, codes and helpers for the directional neighbor select block.
// Used by directional_neighbor_select; no dependencies.
package dns_pkg;

  localparam int MaxCells = 256;
  localparam int CoordW   = 16;
  localparam int IdxW     = $clog2(MaxCells);
  localparam int CntW     = $clog2(MaxCells + 1);
  localparam int RectW    = 4 * CoordW;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [CoordW:0]          dist_t;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;

  localparam logic [1:0] DirUp    = 2'd0;
  localparam logic [1:0] DirDown  = 2'd1;
  localparam logic [1:0] DirLeft  = 2'd2;
  localparam logic [1:0] DirRight = 2'd3;

  // Center of an edge pair, (lo + hi) / 2 truncated toward zero.
  function automatic coord_t center_f(coord_t lo, coord_t hi);
    logic signed [CoordW:0] sum;
    logic signed [CoordW:0] adj;
    begin
      sum = {lo[CoordW-1], lo} + {hi[CoordW-1], hi};
      adj = sum + {{CoordW{1'b0}}, sum[CoordW]};
      center_f = adj[CoordW:1];
    end
  endfunction

endpackage

// File: rtl/core/dns_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module dns_ram #(
  parameter int Width = 64,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/directional_neighbor_select.sv
// Directional neighbor select: cell rectangle table in a RAM plus a scanning search.
// Depends on dns_pkg and dns_ram.
// A write completes while idle; a query reads the current cell, then scans N = min(cell_count,
// 256) cells with one RAM read per scanned cell, then passes center, offset, compare and drain
// stages; an out-of-range query goes straight to done. A new item is taken once the result loads.
// Reset clears control state and cell_count; the cell table is undefined until written.
module directional_neighbor_select (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_cell_count_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [7:0]  cell_index_i,
  input  logic [15:0] rect_left_i,
  input  logic [15:0] rect_top_i,
  input  logic [15:0] rect_right_i,
  input  logic [15:0] rect_bottom_i,
  input  logic [7:0]  current_index_i,
  input  logic [1:0]  direction_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [7:0]  neighbor_index_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCur   = 3'd1;
  localparam logic [2:0] StScan  = 3'd2;
  localparam logic [2:0] StDrain = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;

  localparam int C = dns_pkg::CoordW;

  logic [2:0] state_q, state_d;
  logic [8:0] cnt_q;
  logic [dns_pkg::CntW-1:0] eff_cnt;
  logic [dns_pkg::CntW-1:0] scan_q, scan_d;
  logic [dns_pkg::IdxW-1:0] cur_q, cur_d;
  logic [1:0] dir_q, dir_d;

  logic in_xfer, out_xfer, out_load;
  logic ram_we, ram_re;
  logic [dns_pkg::IdxW-1:0] ram_waddr, ram_raddr, scan_addr;
  logic [dns_pkg::RectW-1:0] ram_wdata, ram_rdata;
  logic scan_issue;

  dns_pkg::coord_t cx0_q, cy0_q;
  dns_pkg::coord_t rd_left, rd_top, rd_right, rd_bottom;

  // scan pipeline: p0 read data, p1 centers, p2 gap and offset
  logic p0_q, p1_q, p2_q;
  logic [dns_pkg::IdxW-1:0] idx0_q, idx1_q, idx2_q;
  dns_pkg::coord_t cx_q, cy_q;
  dns_pkg::dist_t gap_q, perp_q;

  logic signed [C:0] dx, dy, gap_s, perp_s;
  dns_pkg::dist_t perp_abs;

  logic have_q, have_d;
  logic [dns_pkg::IdxW-1:0] best_q, best_d;
  dns_pkg::dist_t best_perp_q, best_perp_d, best_gap_q, best_gap_d;
  logic take;

  logic out_valid_q, found_q;
  logic [7:0] nidx_q;

  assign eff_cnt = (32'(cnt_q) > dns_pkg::MaxCells) ? dns_pkg::CntW'(dns_pkg::MaxCells)
                                                     : dns_pkg::CntW'(cnt_q);

  assign in_stall_o = (state_q != StIdle);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  assign out_load   = (state_q == StDone) && (!out_valid_q || !out_stall_i);

  assign scan_addr  = scan_q[dns_pkg::IdxW-1:0];
  assign scan_issue = (state_q == StScan) && (scan_q < eff_cnt);

  // table writes only happen while idle, so reads never overlap them
  assign ram_we    = in_xfer && (command_i == dns_pkg::CmdWrite)
                     && (32'(cell_index_i) < dns_pkg::MaxCells);
  assign ram_waddr = dns_pkg::IdxW'(cell_index_i);
  assign ram_wdata = {rect_bottom_i[C-1:0], rect_right_i[C-1:0],
                      rect_top_i[C-1:0], rect_left_i[C-1:0]};
  assign ram_re    = (in_xfer && (command_i == dns_pkg::CmdQuery)) || scan_issue;
  assign ram_raddr = (state_q == StIdle) ? dns_pkg::IdxW'(current_index_i) : scan_addr;

  dns_ram #(
    .Width(dns_pkg::RectW),
    .Depth(dns_pkg::MaxCells)
  ) u_cell_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_left   = ram_rdata[C-1:0];
  assign rd_top    = ram_rdata[2*C-1:C];
  assign rd_right  = ram_rdata[3*C-1:2*C];
  assign rd_bottom = ram_rdata[4*C-1:3*C];

  // gap and perpendicular offset per direction
  always_comb begin
    dx = {cx_q[C-1], cx_q} - {cx0_q[C-1], cx0_q};
    dy = {cy_q[C-1], cy_q} - {cy0_q[C-1], cy0_q};
    case (dir_q)
      dns_pkg::DirUp:   begin gap_s = -dy; perp_s = dx; end
      dns_pkg::DirDown: begin gap_s = dy;  perp_s = dx; end
      dns_pkg::DirLeft: begin gap_s = -dx; perp_s = dy; end
      default:          begin gap_s = dx;  perp_s = dy; end
    endcase
    perp_abs = perp_s[C] ? dns_pkg::dist_t'(-perp_s) : dns_pkg::dist_t'(perp_s);
  end

  always_comb begin
    take = p2_q && (!have_q || (perp_q < best_perp_q)
                    || ((perp_q == best_perp_q) && (gap_q < best_gap_q)));
    have_d      = have_q;
    best_d      = best_q;
    best_perp_d = best_perp_q;
    best_gap_d  = best_gap_q;
    if (take) begin
      have_d      = 1'b1;
      best_d      = idx2_q;
      best_perp_d = perp_q;
      best_gap_d  = gap_q;
    end
    if (in_xfer) begin
      have_d = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    cur_d   = cur_q;
    dir_d   = dir_q;
    case (state_q)
      StIdle: begin
        if (in_xfer && (command_i == dns_pkg::CmdQuery)) begin
          cur_d = dns_pkg::IdxW'(current_index_i);
          dir_d = direction_i;
          state_d = (32'(current_index_i) < 32'(eff_cnt)) ? StCur : StDone;
        end
      end
      StCur: begin
        scan_d  = '0;
        state_d = StScan;
      end
      StScan: begin
        if (scan_issue) begin
          scan_d = scan_q + dns_pkg::CntW'(1);
        end else begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (!p0_q && !p1_q && !p2_q) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      p0_q        <= 1'b0;
      p1_q        <= 1'b0;
      p2_q        <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cnt_q <= cfg_cell_count_i;
      end
      // skip the current cell at issue
      p0_q   <= scan_issue && (scan_addr != cur_q);
      p1_q   <= p0_q;
      p2_q   <= p1_q && (gap_s > 0);
      have_q <= have_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q      <= scan_d;
    cur_q       <= cur_d;
    dir_q       <= dir_d;
    idx0_q      <= scan_addr;
    idx1_q      <= idx0_q;
    idx2_q      <= idx1_q;
    cx_q        <= dns_pkg::center_f(rd_left, rd_right);
    cy_q        <= dns_pkg::center_f(rd_top, rd_bottom);
    gap_q       <= dns_pkg::dist_t'(gap_s);
    perp_q      <= perp_abs;
    best_q      <= best_d;
    best_perp_q <= best_perp_d;
    best_gap_q  <= best_gap_d;
    if (state_q == StCur) begin
      cx0_q <= dns_pkg::center_f(rd_left, rd_right);
      cy0_q <= dns_pkg::center_f(rd_top, rd_bottom);
    end
    if (out_load) begin
      found_q <= have_q;
      nidx_q  <= have_q ? 8'(best_q) : 8'd0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign found_o          = found_q;
  assign neighbor_index_o = nidx_q;

endmodule

// File: verif/directional_neighbor_select_tb.sv
// Self-checking testbench for directional_neighbor_select: directed rows, then random phases.
// Each phase sets cell_count, fills the table and mixes writes with neighbor queries.
// Depends on dns_pkg and the directional_neighbor_select RTL.
module directional_neighbor_select_tb;

  typedef struct packed {
    logic                     cmd;
    logic [dns_pkg::IdxW-1:0] cell_idx;
    dns_pkg::coord_t          l;
    dns_pkg::coord_t          t;
    dns_pkg::coord_t          r;
    dns_pkg::coord_t          b;
    logic [dns_pkg::IdxW-1:0] cur;
    logic [1:0]               dir;
  } cell_item_t;

  typedef struct packed {
    logic                     found;
    logic [dns_pkg::IdxW-1:0] idx;
  } neighbor_t;

  typedef struct {
    logic                     is_cfg;
    logic [dns_pkg::CntW-1:0] cfg_val;
    cell_item_t               item;
    logic                     known;
    neighbor_t                want;
  } step_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [dns_pkg::CntW-1:0] cfg_count = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     command = dns_pkg::CmdWrite;
  logic [dns_pkg::IdxW-1:0] cell_index = '0;
  logic [15:0]              rect_left = '0;
  logic [15:0]              rect_top = '0;
  logic [15:0]              rect_right = '0;
  logic [15:0]              rect_bottom = '0;
  logic [dns_pkg::IdxW-1:0] current_index = '0;
  logic [1:0]               direction = dns_pkg::DirUp;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     found;
  logic [dns_pkg::IdxW-1:0] neighbor_index;

  // Shadow copy of the cell table and the count register.
  dns_pkg::coord_t          rect_l [dns_pkg::MaxCells];
  dns_pkg::coord_t          rect_t [dns_pkg::MaxCells];
  dns_pkg::coord_t          rect_r [dns_pkg::MaxCells];
  dns_pkg::coord_t          rect_b [dns_pkg::MaxCells];
  bit                       written [dns_pkg::MaxCells] = '{default: 1'b0};
  logic [dns_pkg::CntW-1:0] model_count = '0;

  neighbor_t       awaited_neighbors [$];
  step_row_t       directed_rows [$];
  bit              no_idle = 1'b0;
  int              mismatches = 0;

  directional_neighbor_select dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_cell_count_i (cfg_count),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .command_i        (command),
    .cell_index_i     (cell_index),
    .rect_left_i      (rect_left),
    .rect_top_i       (rect_top),
    .rect_right_i     (rect_right),
    .rect_bottom_i    (rect_bottom),
    .current_index_i  (current_index),
    .direction_i      (direction),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .found_o          (found),
    .neighbor_index_o (neighbor_index)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int mid(dns_pkg::coord_t lo, dns_pkg::coord_t hi);
    return (int'(lo) + int'(hi)) / 2;
  endfunction

  function automatic neighbor_t pick_neighbor(logic [dns_pkg::IdxW-1:0] cur, logic [1:0] dir);
    neighbor_t res;
    int        eff, cx0, cy0, cx, cy, gap, perp, best_perp, best_gap;
    res = '{1'b0, '0};
    best_perp = 0;
    best_gap = 0;
    eff = (model_count > dns_pkg::MaxCells) ? dns_pkg::MaxCells : int'(model_count);
    if (int'(cur) >= eff) return res;
    cx0 = mid(rect_l[cur], rect_r[cur]);
    cy0 = mid(rect_t[cur], rect_b[cur]);
    for (int i = 0; i < eff; i++) begin
      if (i == int'(cur)) continue;
      cx = mid(rect_l[i], rect_r[i]);
      cy = mid(rect_t[i], rect_b[i]);
      case (dir)
        dns_pkg::DirUp: begin
          gap = cy0 - cy;
          perp = cx - cx0;
        end
        dns_pkg::DirDown: begin
          gap = cy - cy0;
          perp = cx - cx0;
        end
        dns_pkg::DirLeft: begin
          gap = cx0 - cx;
          perp = cy - cy0;
        end
        default: begin
          gap = cx - cx0;
          perp = cy - cy0;
        end
      endcase
      if (gap <= 0) continue;
      if (perp < 0) perp = -perp;
      if (!res.found || perp < best_perp || (perp == best_perp && gap < best_gap)) begin
        res.found = 1'b1;
        res.idx = dns_pkg::IdxW'(i);
        best_perp = perp;
        best_gap = gap;
      end
    end
    return res;
  endfunction

  function automatic step_row_t cfg_row(int val);
    step_row_t row;
    row = '{1'b1, dns_pkg::CntW'(val), '0, 1'b0, '0};
    return row;
  endfunction

  function automatic step_row_t wr_row(int idx, int l, int t, int r, int b);
    step_row_t row;
    // Query fields carry noise: a write ignores them.
    row = '{1'b0, '0, '{dns_pkg::CmdWrite, dns_pkg::IdxW'(idx), dns_pkg::coord_t'(l),
            dns_pkg::coord_t'(t), dns_pkg::coord_t'(r), dns_pkg::coord_t'(b), 8'hA7,
            dns_pkg::DirRight}, 1'b0, '0};
    return row;
  endfunction

  function automatic step_row_t qry_row(int cur, logic [1:0] dir, logic known = 1'b0,
                                        neighbor_t want = '0);
    step_row_t row;
    row = '{1'b0, '0, '{dns_pkg::CmdQuery, 8'h5C, 16'hA5A5, 16'h5A5A, 16'h8001, 16'h7FFE,
            dns_pkg::IdxW'(cur), dir}, known, want};
    return row;
  endfunction

  function automatic dns_pkg::coord_t rand_coord();
    int pick;
    pick = $urandom_range(0, 19);
    // Mostly a narrow range so that equal centers and ties come up often.
    if (pick < 13) return dns_pkg::coord_t'(int'($urandom_range(0, 20)) - 10);
    if (pick == 13) return dns_pkg::coord_t'(-32768);
    if (pick == 14) return dns_pkg::coord_t'(32767);
    return dns_pkg::coord_t'($urandom);
  endfunction

  function automatic cell_item_t rand_item(int eff);
    cell_item_t it;
    it.cmd = ($urandom_range(0, 9) < 4) ? dns_pkg::CmdWrite : dns_pkg::CmdQuery;
    it.l = rand_coord();
    it.t = rand_coord();
    it.r = rand_coord();
    it.b = rand_coord();
    it.dir = 2'($urandom_range(0, 3));
    if (eff > 0 && $urandom_range(0, 9) < 8) begin
      it.cell_idx = dns_pkg::IdxW'($urandom_range(0, eff - 1));
      it.cur = dns_pkg::IdxW'($urandom_range(0, eff - 1));
    end else begin
      it.cell_idx = dns_pkg::IdxW'($urandom);
      it.cur = dns_pkg::IdxW'($urandom);
    end
    return it;
  endfunction

  task automatic send_item(input cell_item_t it, input logic known, input neighbor_t want);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    command = it.cmd;
    cell_index = it.cell_idx;
    rect_left = it.l;
    rect_top = it.t;
    rect_right = it.r;
    rect_bottom = it.b;
    current_index = it.cur;
    direction = it.dir;
    do @(posedge clk); while (in_stall);
    if (it.cmd == dns_pkg::CmdWrite) begin
      rect_l[it.cell_idx] = it.l;
      rect_t[it.cell_idx] = it.t;
      rect_r[it.cell_idx] = it.r;
      rect_b[it.cell_idx] = it.b;
      written[it.cell_idx] = 1'b1;
    end else if (known) begin
      awaited_neighbors.push_back(want);
    end else begin
      awaited_neighbors.push_back(pick_neighbor(it.cur, it.dir));
    end
  endtask

  // Drop valid, drain all results and let a trailing write finish.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_neighbors.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_cell_count(input logic [dns_pkg::CntW-1:0] val);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_count = val;
    @(negedge clk);
    cfg_we = 1'b0;
    model_count = val;
  endtask

  always @(posedge clk) begin
    neighbor_t exp_n;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_neighbors.size() == 0) begin
        $error("neighbor result with nothing awaited: found %0d index %0d",
               found, neighbor_index);
        mismatches++;
      end else begin
        exp_n = awaited_neighbors.pop_front();
        if (found !== exp_n.found) begin
          $error("found: expected %0d, got %0d", exp_n.found, found);
          mismatches++;
        end
        if (neighbor_index !== exp_n.idx) begin
          $error("neighbor_index: expected %0d, got %0d", exp_n.idx, neighbor_index);
          mismatches++;
        end
      end
    end
  end

  // Result side: random hold per transfer, plus long hold-offs to back up the input.
  initial begin : result_sink
    int hold;
    int got;
    got = 0;
    @(posedge rst_n);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 14);
      if (got == 60 || got == 400) hold = 300;
      if (hold > 0) begin
        @(negedge clk);
        out_stall = 1'b1;
        if ($urandom_range(0, 1) == 1) do @(posedge clk); while (!out_valid);
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      got++;
    end
  end

  initial begin : stimulus
    cell_item_t it;
    int         sel, eff, n, sent;
    logic [dns_pkg::CntW-1:0] cnt;

    directed_rows.push_back(cfg_row(0));
    directed_rows.push_back(qry_row(0, dns_pkg::DirUp, 1'b1, '{1'b0, '0}));    // empty table
    directed_rows.push_back(wr_row(0, 0, 0, 0, 0));
    directed_rows.push_back(wr_row(1, -32768, -32768, -32768, -32768));
    directed_rows.push_back(wr_row(2, 32767, 32767, 32767, 32767));
    directed_rows.push_back(wr_row(3, -32768, -32768, 32767, 32767));  // center truncates to 0
    directed_rows.push_back(wr_row(4, 1, 2, 2, 4));
    directed_rows.push_back(wr_row(5, -3, -3, 0, 0));                  // -3/2 rounds to -1
    directed_rows.push_back(wr_row(6, 10, 10, 10, 10));
    directed_rows.push_back(wr_row(7, 10, 10, 10, 10));                // tie: lower index wins
    directed_rows.push_back(wr_row(255, -32768, 32767, 32767, -32768));
    directed_rows.push_back(cfg_row(1));
    directed_rows.push_back(qry_row(0, dns_pkg::DirRight, 1'b1, '{1'b0, '0})); // lone cell
    directed_rows.push_back(cfg_row(8));
    directed_rows.push_back(qry_row(0, dns_pkg::DirUp));
    directed_rows.push_back(qry_row(0, dns_pkg::DirDown));
    directed_rows.push_back(qry_row(0, dns_pkg::DirLeft));
    directed_rows.push_back(qry_row(0, dns_pkg::DirRight));
    directed_rows.push_back(qry_row(5, dns_pkg::DirRight));
    directed_rows.push_back(qry_row(3, dns_pkg::DirLeft));
    directed_rows.push_back(qry_row(1, dns_pkg::DirDown));
    directed_rows.push_back(qry_row(2, dns_pkg::DirUp));
    directed_rows.push_back(qry_row(8, dns_pkg::DirDown, 1'b1, '{1'b0, '0}));  // past count
    directed_rows.push_back(qry_row(255, dns_pkg::DirLeft, 1'b1, '{1'b0, '0}));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[k]) begin
      if (directed_rows[k].is_cfg) set_cell_count(directed_rows[k].cfg_val);
      else send_item(directed_rows[k].item, directed_rows[k].known, directed_rows[k].want);
    end

    sent = 0;
    while (sent < 1200) begin
      sel = $urandom_range(0, 19);
      case (sel)
        0: cnt = '0;
        1: cnt = dns_pkg::CntW'(1);
        2: cnt = dns_pkg::CntW'(2);
        3: cnt = dns_pkg::CntW'(dns_pkg::MaxCells);
        4: cnt = ($urandom_range(0, 1) == 1) ? 9'd511
                                             : dns_pkg::CntW'($urandom_range(257, 510));
        5: cnt = dns_pkg::CntW'($urandom_range(200, 255));
        default: cnt = dns_pkg::CntW'($urandom_range(3, 12));
      endcase
      set_cell_count(cnt);
      eff = (cnt > dns_pkg::MaxCells) ? dns_pkg::MaxCells : int'(cnt);
      no_idle = ($urandom_range(0, 4) == 0);
      // Fill every searched entry before any query can read it.
      for (int i = 0; i < eff; i++) begin
        if (!written[i]) begin
          it = rand_item(eff);
          it.cmd = dns_pkg::CmdWrite;
          it.cell_idx = dns_pkg::IdxW'(i);
          send_item(it, 1'b0, '0);
          sent++;
        end
      end
      n = (eff > 100) ? 15 : $urandom_range(20, 60);
      repeat (n) begin
        send_item(rand_item(eff), 1'b0, '0);
        sent++;
      end
    end

    no_idle = 1'b0;
    drain();
    if (mismatches == 0) begin
      $display("** directional_neighbor_select: PASSED **");
    end else begin
      $display("** directional_neighbor_select: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #15_000_000;
    $display("** directional_neighbor_select: FAILED **");
    $finish;
  end

endmodule
